// ===== hdl/mmhq_pkg.sv =====
// Package for the min-max heap queue: widths, action and status codes,
// and the comparator request type. Used by every file of the block.
package mmhq_pkg;
    localparam int Capacity = 1023;
    localparam int KeyBits = 32;
    localparam int TagBits = 32;
    localparam int PosBits = $clog2(Capacity + 1);
    localparam int FillBits = 10;

    localparam logic [1:0] ACT_INSERT = 2'd0;
    localparam logic [1:0] ACT_EXT_MIN = 2'd1;
    localparam logic [1:0] ACT_EXT_MAX = 2'd2;

    localparam logic [1:0] ST_DONE = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    typedef logic [KeyBits-1:0] key_t;
    typedef logic [TagBits-1:0] tag_t;
    typedef logic [PosBits-1:0] pos_t;

    // Compare request to the shared comparator.
    typedef struct packed {
        key_t a;
        key_t b;
        logic want_min;
    } cmp_req_t;

    // Position depth parity: true on min levels (even depth).
    function automatic logic min_level(input pos_t p);
        logic lvl;
        lvl = 1'b1;
        for (int i = 1; i < PosBits; i++)
        begin
            if (p[i])
                lvl = ((i % 2) == 0);
        end
        return lvl;
    endfunction
endpackage

// ===== hdl/mmhq_cmp.sv =====
// Shared key comparator of the min-max heap queue.
// Depends on mmhq_pkg for the key type and request struct.
module mmhq_cmp (
    input  mmhq_pkg::cmp_req_t req,
    output logic               better
);
    import mmhq_pkg::*;

    // Keys are signed; a beats b strictly on a level of the requested kind.
    always_comb
    begin
        if (req.want_min)
            better = $signed(req.a) < $signed(req.b);
        else
            better = $signed(req.a) > $signed(req.b);
    end
endmodule

// ===== hdl/min_max_heap_queue_core.sv =====
// Min-max heap queue: double-ended priority queue in one key/tag memory.
// Insert reads, waits on and compares against each ancestor level climbed; extract picks
// and refills the removed slot, then trickles down two levels at a time (six candidate
// reads through one memory port, swap, parent check).
// One item at a time; busy while working.
// Reset clears the entry count and control state; the store needs no clearing pass.
// The result strobe lasts one cycle and cannot be stalled.
module min_max_heap_queue_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [1:0]           action,
    input  logic signed [31:0]   new_key,
    input  logic [31:0]          new_tag,
    output logic                 done,
    output logic [1:0]           status,
    output logic signed [31:0]   out_key,
    output logic [31:0]          out_tag,
    output logic [9:0]           fill
);
    import mmhq_pkg::*;

    typedef enum logic [10:0] {
        S_IDLE   = 11'b00000000001,
        S_RD     = 11'b00000000010,
        S_RDW    = 11'b00000000100,
        S_UP     = 11'b00000001000,
        S_MAXSEL = 11'b00000010000,
        S_TDCUR  = 11'b00000100000,
        S_TDSCAN = 11'b00001000000,
        S_TDSWAP = 11'b00010000000,
        S_TDPAR  = 11'b00100000000,
        S_WR     = 11'b01000000000,
        S_FIN    = 11'b10000000000
    } state_t;

    // Key and tag memory, one read and one write port.
    key_t key_mem [1:Capacity];
    tag_t tag_mem [1:Capacity];
    pos_t rd_addr;
    key_t rd_key;
    tag_t rd_tag;
    logic wr_en;
    pos_t wr_addr;
    key_t wr_key;
    tag_t wr_tag;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            key_mem[wr_addr] <= wr_key;
            tag_mem[wr_addr] <= wr_tag;
        end
        rd_key <= key_mem[rd_addr];
        rd_tag <= tag_mem[rd_addr];
    end

    state_t state_reg, state_next;
    state_t ret_reg, ret_next;
    pos_t count_reg, count_next;
    pos_t pos_reg, pos_next;          // position of the moving entry
    key_t mkey_reg, mkey_next;        // moving entry
    tag_t mtag_reg, mtag_next;
    pos_t opos_reg, opos_next;        // other position being read
    key_t okey_reg, okey_next;
    logic [2:0] step_reg, step_next;
    pos_t best_reg, best_next;
    key_t bkey_reg, bkey_next;
    tag_t btag_reg, btag_next;
    logic [1:0] stat_reg, stat_next;
    key_t rkey_reg, rkey_next;
    tag_t rtag_reg, rtag_next;
    logic done_reg, done_next;

    cmp_req_t creq;
    logic cbetter;
    mmhq_cmp u_cmp (.req(creq), .better(cbetter));

    logic lvl_min;

    always_comb
    begin
        state_next = state_reg;
        ret_next = ret_reg;
        count_next = count_reg;
        pos_next = pos_reg;
        mkey_next = mkey_reg;
        mtag_next = mtag_reg;
        opos_next = opos_reg;
        okey_next = okey_reg;
        step_next = step_reg;
        best_next = best_reg;
        bkey_next = bkey_reg;
        btag_next = btag_reg;
        stat_next = stat_reg;
        rkey_next = rkey_reg;
        rtag_next = rtag_reg;
        done_next = 1'b0;
        rd_addr = opos_reg;
        wr_en = 1'b0;
        wr_addr = pos_reg;
        wr_key = mkey_reg;
        wr_tag = mtag_reg;
        creq.a = mkey_reg;
        creq.b = rd_key;
        creq.want_min = 1'b1;
        lvl_min = min_level(pos_reg);
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    stat_next = ST_DONE;
                    rkey_next = '0;
                    rtag_next = '0;
                    if (action == ACT_INSERT)
                    begin
                        if (count_reg >= pos_t'(Capacity))
                        begin
                            stat_next = ST_FULL;
                            state_next = S_FIN;
                        end
                        else
                        begin
                            count_next = count_reg + 1'b1;
                            pos_next = count_reg + 1'b1;
                            mkey_next = new_key;
                            mtag_next = new_tag;
                            opos_next = pos_t'((count_reg + 1'b1) >> 1);
                            if (count_reg == '0)
                                state_next = S_WR;
                            else
                                state_next = S_RD;
                            ret_next = S_UP;
                            step_next = 3'd0;
                        end
                    end
                    else if (action == ACT_EXT_MIN || action == ACT_EXT_MAX)
                    begin
                        if (count_reg == '0)
                        begin
                            stat_next = ST_EMPTY;
                            state_next = S_FIN;
                        end
                        else if (action == ACT_EXT_MAX && count_reg >= pos_t'(3))
                        begin
                            opos_next = pos_t'(2);
                            state_next = S_RD;
                            ret_next = S_MAXSEL;
                            step_next = 3'd0;
                        end
                        else
                        begin
                            pos_next = (action == ACT_EXT_MAX && count_reg == pos_t'(2))
                                       ? pos_t'(2) : pos_t'(1);
                            opos_next = pos_next;
                            state_next = S_RD;
                            ret_next = S_TDCUR;
                            step_next = 3'd0;
                        end
                    end
                    else
                        state_next = S_FIN;
                end
            end
            S_RD:
                state_next = S_RDW;
            S_RDW:
                state_next = ret_reg;
            // Bubble up: compare against parent (step 0) then grandparent (1).
            S_UP:
            begin
                creq.want_min = (step_reg == 3'd0) ? !lvl_min : lvl_min;
                if (cbetter)
                begin
                    // Drop the other entry into the moving entry's slot.
                    wr_en = 1'b1;
                    wr_addr = pos_reg;
                    wr_key = rd_key;
                    wr_tag = rd_tag;
                    pos_next = opos_reg;
                    step_next = 3'd0;
                    if (opos_reg == pos_t'(1))
                        state_next = S_WR;
                    else
                    begin
                        opos_next = opos_reg >> 1;
                        state_next = S_RD;
                    end
                end
                else if (step_reg == 3'd0 && (opos_reg >> 1) != '0)
                begin
                    step_next = 3'd1;
                    opos_next = opos_reg >> 1;
                    state_next = S_RD;
                end
                else
                    state_next = S_WR;
            end
            // Maximum choice between positions 2 and 3, ties to 3.
            S_MAXSEL:
            begin
                if (step_reg == 3'd0)
                begin
                    okey_next = rd_key;
                    opos_next = pos_t'(3);
                    step_next = 3'd1;
                    state_next = S_RD;
                end
                else
                begin
                    creq.a = okey_reg;
                    creq.want_min = 1'b0;
                    pos_next = cbetter ? pos_t'(2) : pos_t'(3);
                    opos_next = pos_next;
                    step_next = 3'd0;
                    state_next = S_RD;
                    ret_next = S_TDCUR;
                end
            end
            // Report the removed entry, then fetch the last one to refill.
            S_TDCUR:
            begin
                if (step_reg == 3'd0)
                begin
                    rkey_next = rd_key;
                    rtag_next = rd_tag;
                    count_next = count_reg - 1'b1;
                    if (pos_reg == count_reg)
                        state_next = S_FIN;
                    else
                    begin
                        opos_next = count_reg;
                        step_next = 3'd1;
                        state_next = S_RD;
                    end
                end
                else
                begin
                    mkey_next = rd_key;
                    mtag_next = rd_tag;
                    best_next = pos_reg;
                    bkey_next = rd_key;
                    btag_next = rd_tag;
                    step_next = 3'd0;
                    opos_next = pos_t'({1'b0, pos_reg, 1'b0});
                    if ({1'b0, pos_reg, 1'b0} > {2'b0, count_reg})
                        state_next = S_WR;
                    else
                    begin
                        state_next = S_RD;
                        ret_next = S_TDSCAN;
                    end
                end
            end
            // Scan the descendants present, up to six, one by one.
            S_TDSCAN:
            begin
                creq.a = rd_key;
                creq.b = bkey_reg;
                creq.want_min = lvl_min;
                if (cbetter)
                begin
                    best_next = opos_reg;
                    bkey_next = rd_key;
                    btag_next = rd_tag;
                end
                begin
                    logic [PosBits+1:0] nc;
                    nc = '0;
                    case (step_reg)
                        3'd0: nc = {1'b0, pos_reg, 1'b1};
                        3'd1: nc = {pos_reg, 2'd0};
                        3'd2: nc = {pos_reg, 2'd1};
                        3'd3: nc = {pos_reg, 2'd2};
                        default: nc = {pos_reg, 2'd3};
                    endcase
                    if (step_reg != 3'd5 && nc <= {2'b0, count_reg})
                    begin
                        step_next = step_reg + 1'b1;
                        opos_next = nc[PosBits-1:0];
                        state_next = S_RD;
                    end
                    else
                        state_next = S_TDSWAP;
                end
            end
            // Move the best descendant up into the current slot.
            S_TDSWAP:
            begin
                if (best_reg == pos_reg)
                    state_next = S_WR;
                else
                begin
                    wr_en = 1'b1;
                    wr_addr = pos_reg;
                    wr_key = bkey_reg;
                    wr_tag = btag_reg;
                    if ({2'b0, best_reg} >= {pos_reg, 2'd0})
                    begin
                        opos_next = best_reg >> 1;
                        pos_next = best_reg;
                        step_next = 3'd0;
                        state_next = S_RD;
                        ret_next = S_TDPAR;
                    end
                    else
                    begin
                        pos_next = best_reg;
                        state_next = S_WR;
                    end
                end
            end
            // Fix the order against the grandchild's parent, then go on.
            S_TDPAR:
            begin
                creq.a = rd_key;
                creq.b = mkey_reg;
                creq.want_min = min_level(opos_reg >> 1);
                if (cbetter)
                begin
                    wr_en = 1'b1;
                    wr_addr = opos_reg;
                    wr_key = mkey_reg;
                    wr_tag = mtag_reg;
                    mkey_next = rd_key;
                    mtag_next = rd_tag;
                    bkey_next = rd_key;
                    btag_next = rd_tag;
                end
                else
                begin
                    bkey_next = mkey_reg;
                    btag_next = mtag_reg;
                end
                best_next = pos_reg;
                step_next = 3'd0;
                opos_next = pos_t'({1'b0, pos_reg, 1'b0});
                if ({1'b0, pos_reg, 1'b0} > {2'b0, count_reg})
                    state_next = S_WR;
                else
                begin
                    state_next = S_RD;
                    ret_next = S_TDSCAN;
                end
            end
            S_WR:
            begin
                wr_en = 1'b1;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                done_next = 1'b1;
                state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ret_reg <= S_IDLE;
            count_reg <= '0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg <= ret_next;
            count_reg <= count_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg <= pos_next;
        mkey_reg <= mkey_next;
        mtag_reg <= mtag_next;
        opos_reg <= opos_next;
        okey_reg <= okey_next;
        best_reg <= best_next;
        bkey_reg <= bkey_next;
        btag_reg <= btag_next;
        stat_reg <= stat_next;
        rkey_reg <= rkey_next;
        rtag_reg <= rtag_next;
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;
    assign status = stat_reg;
    assign out_key = rkey_reg;
    assign out_tag = rtag_reg;
    assign fill = FillBits'(count_reg);

    // The result strobe only follows the finishing state.
    a_done_after_fin: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == S_FIN))
        else $error("result strobe without finishing state");

    // The entry count never exceeds capacity.
    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= pos_t'(Capacity))
        else $error("entry count above capacity");

    // Nothing is written to the store while idle.
    a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !wr_en)
        else $error("store written while idle");
endmodule
